// ===== design/dbmd_pkg.sv =====
// Shared types, codes and the duty scaling function of the button motor controller.
`timescale 1ns / 1ps
`default_nettype none
package dbmd_pkg;

  localparam int NUM_BUTTONS = 3;
  localparam int DEB_W       = 10;
  localparam int COOL_W      = 12;
  localparam int STABLE_W    = 11;
  localparam int COOLCNT_W   = 13;
  localparam int POT_W       = 10;
  localparam int DUTY_W      = 8;
  localparam int MODE_W      = 2;
  localparam int CFG_DATA_W  = 12;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 10'd50;
  localparam logic [COOL_W-1:0] COOLDOWN_RESET = 12'd250;
  localparam logic [STABLE_W-1:0]  STABLE_MAX = '1;
  localparam logic [COOLCNT_W-1:0] COOL_MAX   = '1;

  // Button order within the packed raw and event vectors.
  localparam int IDX_STOP = 0;
  localparam int IDX_FWD  = 1;
  localparam int IDX_REV  = 2;

  // Motor mode codes.
  localparam logic [MODE_W-1:0] MODE_STOP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FWD  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REV  = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_DEBOUNCE = 1'b0;
  localparam logic CFG_COOLDOWN = 1'b1;

  // Press events from the debouncers to the mode controller.
  typedef struct packed {
    logic stop;
    logic fwd;
    logic rev;
  } press_t;

  // sample * 255 / 1023, truncated. The division uses x = q*1024 + lo, so the
  // remainder against 1023 is q + lo, which stays below twice 1023.
  function automatic logic [DUTY_W-1:0] duty_scale(input logic [POT_W-1:0] pot);
    logic [17:0]         prod;
    logic [DUTY_W-1:0]   q0;
    logic [POT_W:0]      rem;
    prod = {8'd0, pot} * 18'd255;
    q0   = prod[17:10];
    rem  = {3'd0, q0} + {1'b0, prod[9:0]};
    return q0 + DUTY_W'(rem >= 11'd1023);
  endfunction

endpackage
`default_nettype wire

// ===== design/debounced_button_motor_direction_ctrl.sv =====
// Top level of the debounced three-button motor direction controller.
// Each request is one millisecond tick carrying three raw button levels and a
// potentiometer sample; each produces exactly one result with the bridge pins,
// the PWM duty and the motor mode after that tick. The block takes one request
// per clock while its input is not stalled, and each passes through the input
// register and then the result register, with all per-tick state (debouncers,
// cooldown counter, mode) updated as it moves from the one to the other.
// A new request is still taken into an empty input register while a
// finished result waits under stall. Debounced levels start released
// after reset, and the counters start at zero, so presses in the first
// debounce and cooldown windows after reset are filtered and locked out.
// Configuration writes (index 0 debounce ticks, index 1 cooldown ticks) take
// effect from the next tick and should be issued only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module debounced_button_motor_direction_ctrl
  import dbmd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Configuration write port.
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // Tick requests.
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_stop_raw,
  input  wire logic                  in_forward_raw,
  input  wire logic                  in_reverse_raw,
  input  wire logic [POT_W-1:0]      in_pot_sample,
  // Results.
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_drive_a,
  output logic                       out_drive_b,
  output logic [DUTY_W-1:0]          out_duty,
  output logic [MODE_W-1:0]          out_mode
);

  // Configuration registers.
  logic [DEB_W-1:0]  debounce_ticks_r;
  logic [COOL_W-1:0] cooldown_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r <= DEBOUNCE_RESET;
      cooldown_ticks_r <= COOLDOWN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE: debounce_ticks_r <= cfg_wdata[DEB_W-1:0];
        CFG_COOLDOWN: cooldown_ticks_r <= cfg_wdata[COOL_W-1:0];
        default:      debounce_ticks_r <= debounce_ticks_r;
      endcase
    end
  end

  // Input register. It moves on whenever the result register is free or is
  // being emptied in this cycle.
  logic                   s1_valid_r;
  logic [NUM_BUTTONS-1:0] s1_raw_r;
  logic [POT_W-1:0]       s1_pot_r;
  logic                   s1_adv;
  logic                   in_take;

  assign s1_adv   = s1_valid_r && (!out_valid || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_raw_r[IDX_STOP] <= in_stop_raw;
      s1_raw_r[IDX_FWD]  <= in_forward_raw;
      s1_raw_r[IDX_REV]  <= in_reverse_raw;
      s1_pot_r           <= in_pot_sample;
    end
  end

  // Per-button debouncers; their state advances once per tick.
  logic [NUM_BUTTONS-1:0] press_vec;
  press_t                 press;

  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
    dbmd_debounce u_deb (
      .clk            (clk),
      .rst_n          (rst_n),
      .tick_en        (s1_adv),
      .raw            (s1_raw_r[b]),
      .debounce_ticks (debounce_ticks_r),
      .press          (press_vec[b])
    );
  end

  assign press.stop = press_vec[IDX_STOP];
  assign press.fwd  = press_vec[IDX_FWD];
  assign press.rev  = press_vec[IDX_REV];

  // Mode controller gives the mode that holds after this tick.
  logic [MODE_W-1:0] mode_nxt;

  dbmd_mode_ctrl u_mode (
    .clk            (clk),
    .rst_n          (rst_n),
    .tick_en        (s1_adv),
    .press          (press),
    .cooldown_ticks (cooldown_ticks_r),
    .mode_nxt       (mode_nxt)
  );

  // Result register. Mode code 3 is never entered; it would drive like stop.
  logic              out_valid_r;
  logic              drive_a_nxt, drive_b_nxt;
  logic [DUTY_W-1:0] duty_nxt, scaled;
  logic              drive_a_r, drive_b_r;
  logic [DUTY_W-1:0] duty_r;
  logic [MODE_W-1:0] mode_out_r;

  assign scaled = duty_scale(s1_pot_r);

  always_comb begin
    drive_a_nxt = 1'b0;
    drive_b_nxt = 1'b0;
    duty_nxt    = '0;
    if (mode_nxt == MODE_FWD) begin
      drive_a_nxt = 1'b1;
      duty_nxt    = scaled;
    end else if (mode_nxt == MODE_REV) begin
      drive_b_nxt = 1'b1;
      duty_nxt    = scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      drive_a_r  <= drive_a_nxt;
      drive_b_r  <= drive_b_nxt;
      duty_r     <= duty_nxt;
      mode_out_r <= mode_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_drive_a = drive_a_r;
  assign out_drive_b = drive_b_r;
  assign out_duty    = duty_r;
  assign out_mode    = mode_out_r;

  // The bridge must never be driven in both directions at once.
  a_no_shoot_through: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(drive_a_r && drive_b_r))
    else $error("both bridge pins driven high");

  // A stopped motor gets no duty, and pins follow the mode.
  a_stop_no_duty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && mode_out_r == MODE_STOP) |-> (duty_r == '0 && !drive_a_r && !drive_b_r))
    else $error("stop mode with nonzero drive");

  // A request is held back only while the input register cannot move on.
  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

  // A finished result moves to the output only if the previous one left.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> !$past(s1_adv))
    else $error("result overwritten while stalled");

endmodule
`default_nettype wire

// ===== design/dbmd_debounce.sv =====
// Debouncer for one button: stable-tick counter, accepted level and press event.
`timescale 1ns / 1ps
`default_nettype none
module dbmd_debounce
  import dbmd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             tick_en,
  input  wire logic             raw,
  input  wire logic [DEB_W-1:0] debounce_ticks,
  output logic                  press
);

  logic                prev_r, prev_nxt;
  logic                deb_r, deb_nxt;
  logic [STABLE_W-1:0] cnt_r, cnt_nxt;
  logic                take;

  always_comb begin
    prev_nxt = raw;
    if (raw != prev_r) begin
      cnt_nxt = '0;
    end else if (cnt_r != STABLE_MAX) begin
      cnt_nxt = cnt_r + 1'b1;
    end else begin
      cnt_nxt = cnt_r;
    end
    take    = (cnt_nxt > {1'b0, debounce_ticks}) && (raw != deb_r);
    deb_nxt = take ? raw : deb_r;
    press   = tick_en && take && raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= 1'b0;
      deb_r  <= 1'b0;
      cnt_r  <= '0;
    end else if (tick_en) begin
      prev_r <= prev_nxt;
      deb_r  <= deb_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/dbmd_mode_ctrl.sv =====
// Mode selection with press priority and cooldown lockout.
`timescale 1ns / 1ps
`default_nettype none
module dbmd_mode_ctrl
  import dbmd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              tick_en,
  input  wire press_t            press,
  input  wire logic [COOL_W-1:0] cooldown_ticks,
  output logic [MODE_W-1:0]      mode_nxt
);

  logic [MODE_W-1:0]    mode_r;
  logic [COOLCNT_W-1:0] cool_r, cool_inc, cool_nxt;
  logic                 open;

  always_comb begin
    cool_inc = (cool_r != COOL_MAX) ? cool_r + 1'b1 : cool_r;
    open     = cool_inc > {1'b0, cooldown_ticks};
    mode_nxt = mode_r;
    cool_nxt = cool_inc;
    if (open) begin
      if (press.stop) begin
        mode_nxt = MODE_STOP;
        cool_nxt = '0;
      end else if (press.fwd) begin
        mode_nxt = MODE_FWD;
        cool_nxt = '0;
      end else if (press.rev) begin
        mode_nxt = MODE_REV;
        cool_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_STOP;
      cool_r <= '0;
    end else if (tick_en) begin
      mode_r <= mode_nxt;
      cool_r <= cool_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/tb_debounced_button_motor_direction_ctrl.sv =====
// Self-checking testbench for the debounced three-button motor direction controller.
`timescale 1ns / 1ps
module tb_debounced_button_motor_direction_ctrl;
  import dbmd_pkg::*;

  // Duty scaling constants: the sample range maps onto the PWM range.
  localparam int POT_FULL  = 1023;
  localparam int DUTY_FULL = 255;

  // Extra quiet allowed once the block has answered every request it took,
  // before the next register write or the final verdict.
  localparam int SETTLE_CYCLES = 4;

  // The watchdog trips after this many cycles without any handshake. The
  // longest correct quiet stretch is the forced receiver hold plus one long
  // random gap on the other side, well under this figure.
  localparam int IDLE_LIMIT = 1000;

  // Length of the forced receiver hold used to fill the block up.
  localparam int HOLD_CYCLES = 150;

  // Random part of the run, counted in tick requests.
  localparam int RANDOM_TICKS = 500;
  localparam int PHASE_TICKS  = 160;

  // One result as seen on the output port.
  typedef struct packed {
    logic              drive_a;
    logic              drive_b;
    logic [DUTY_W-1:0] duty;
    logic [MODE_W-1:0] mode;
  } drive_result_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_we;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  logic             in_valid;
  logic             in_stall;
  logic             in_stop_raw;
  logic             in_forward_raw;
  logic             in_reverse_raw;
  logic [POT_W-1:0] in_pot_sample;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_drive_a;
  logic              out_drive_b;
  logic [DUTY_W-1:0] out_duty;
  logic [MODE_W-1:0] out_mode;

  debounced_button_motor_direction_ctrl dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_stop_raw    (in_stop_raw),
    .in_forward_raw (in_forward_raw),
    .in_reverse_raw (in_reverse_raw),
    .in_pot_sample  (in_pot_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_drive_a    (out_drive_a),
    .out_drive_b    (out_drive_b),
    .out_duty       (out_duty),
    .out_mode       (out_mode)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shared run state. Sender gaps and random receiver stalls happen only while
  // their flags are set; the test sequence turns them off for stretches of full rate.
  bit tx_gaps_on   = 1'b1;
  bit rx_stalls_on = 1'b1;
  int hold_requests = 0;
  int ticks_sent    = 0;
  int mismatches    = 0;
  int idle_cycles   = 0;

  // Results predicted for accepted requests, oldest first.
  drive_result_t pending_drives[$];

  // Mirror of the controller: register settings and per-tick state.
  logic [DEB_W-1:0]     set_debounce;
  logic [COOL_W-1:0]    set_cooldown;
  logic [2:0]           deb_level;
  logic [2:0]           last_raw;
  logic [STABLE_W-1:0]  stable_cnt [NUM_BUTTONS];
  logic [COOLCNT_W-1:0] lock_cnt;
  logic [MODE_W-1:0]    cur_mode;

  // ------------------------------------------------------------------
  // Predictor and checker
  // ------------------------------------------------------------------

  task automatic clear_mirror();
    set_debounce = DEBOUNCE_RESET;
    set_cooldown = COOLDOWN_RESET;
    deb_level    = '0;
    last_raw     = '0;
    for (int b = 0; b < NUM_BUTTONS; b++) stable_cnt[b] = '0;
    lock_cnt = '0;
    cur_mode = MODE_STOP;
  endtask

  // Advances the mirror by one tick and queues the result that tick must give.
  task automatic predict_drive(input logic [2:0] raw, input logic [POT_W-1:0] pot);
    logic [2:0]    press;
    int            scaled;
    drive_result_t want;
    // Each button: a raw change restarts its stable count, which saturates.
    // Once the count passes the debounce setting the raw level is accepted,
    // and an accepted rise is a press.
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      press[b] = 1'b0;
      if (raw[b] != last_raw[b]) begin
        stable_cnt[b] = '0;
        last_raw[b]   = raw[b];
      end else if (stable_cnt[b] != STABLE_MAX) begin
        stable_cnt[b] = stable_cnt[b] + 1'b1;
      end
      if (stable_cnt[b] > set_debounce && raw[b] != deb_level[b]) begin
        deb_level[b] = raw[b];
        press[b]     = raw[b];
      end
    end
    // Presses act only once the lockout window since the last change is over.
    if (lock_cnt != COOL_MAX) lock_cnt = lock_cnt + 1'b1;
    if (lock_cnt > set_cooldown) begin
      if (press[IDX_STOP]) begin
        cur_mode = MODE_STOP;
        lock_cnt = '0;
      end else if (press[IDX_FWD]) begin
        cur_mode = MODE_FWD;
        lock_cnt = '0;
      end else if (press[IDX_REV]) begin
        cur_mode = MODE_REV;
        lock_cnt = '0;
      end
    end
    scaled = (int'(pot) * DUTY_FULL) / POT_FULL;
    case (cur_mode)
      MODE_FWD: begin
        want = '{1'b1, 1'b0, scaled[DUTY_W-1:0], cur_mode};
      end
      MODE_REV: begin
        want = '{1'b0, 1'b1, scaled[DUTY_W-1:0], cur_mode};
      end
      default: begin
        want = '{1'b0, 1'b0, '0, cur_mode};
      end
    endcase
    pending_drives.push_back(want);
  endtask

  task automatic flag_mismatch(input string what);
    if (mismatches < 40) $display("MISMATCH at %0t ns: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic check_drive();
    drive_result_t want;
    if (pending_drives.size() == 0) begin
      flag_mismatch($sformatf("result with no request pending (mode %0d duty %0d)",
                              out_mode, out_duty));
      return;
    end
    want = pending_drives.pop_front();
    if (out_drive_a !== want.drive_a)
      flag_mismatch($sformatf("drive_a %b, predicted %b", out_drive_a, want.drive_a));
    if (out_drive_b !== want.drive_b)
      flag_mismatch($sformatf("drive_b %b, predicted %b", out_drive_b, want.drive_b));
    if (out_duty !== want.duty)
      flag_mismatch($sformatf("duty %0d, predicted %0d", out_duty, want.duty));
    if (out_mode !== want.mode)
      flag_mismatch($sformatf("mode %0d, predicted %0d", out_mode, want.mode));
  endtask

  // Everything is sampled at the rising edge. A result leaving at this edge
  // always belongs to an older request than one entering, so the check runs
  // before the new prediction is queued.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_mirror();
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) check_drive();
      if (cfg_we === 1'b1) begin
        if (cfg_index == CFG_DEBOUNCE) set_debounce = cfg_wdata[DEB_W-1:0];
        else set_cooldown = cfg_wdata[COOL_W-1:0];
      end
      if (in_valid === 1'b1 && in_stall === 1'b0)
        predict_drive({in_reverse_raw, in_forward_raw, in_stop_raw}, in_pot_sample);
    end
  end

  // Watchdog: any handshake on either side counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------

  // Mostly zero, often a short pause, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // Potentiometer sample with the two ends of the range favored.
  function automatic logic [POT_W-1:0] pick_pot();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return POT_W'($urandom_range(0, POT_FULL));
  endfunction

  // Receiver: random stall bursts, plus a long forced hold whenever the test
  // sequence asks for one. The hold is counted here, in this process.
  initial begin : result_stall_gen
    int stall_left;
    int hold_left;
    int holds_done;
    stall_left = 0;
    hold_left  = 0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_requests) begin
        holds_done = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (!rx_stalls_on) begin
        out_stall  = 1'b0;
        stall_left = 0;
      end else begin
        if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        out_stall = (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Sends one tick request. Entered and left at a falling edge; valid stays
  // high on return so back-to-back requests follow without a gap.
  task automatic send_tick(input logic [2:0] btns, input logic [POT_W-1:0] pot);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_stop_raw    = btns[IDX_STOP];
    in_forward_raw = btns[IDX_FWD];
    in_reverse_raw = btns[IDX_REV];
    in_pot_sample  = pot;
    in_valid       = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
    ticks_sent++;
  endtask

  // Stops sending and waits until every predicted result has come out,
  // then gives the block the settle period to go quiet.
  task automatic settle_block();
    in_valid = 1'b0;
    while (pending_drives.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Writes both registers with the block idle. The debounce write carries
  // random bits above its width, which the block must drop.
  task automatic set_timing(input int debounce, input int cooldown);
    settle_block();
    cfg_write(CFG_DEBOUNCE, {2'($urandom), DEB_W'(debounce)});
    cfg_write(CFG_COOLDOWN, COOL_W'(cooldown));
  endtask

  // One button action: contact bounce, a hold, bounce on release, then rest.
  task automatic press_and_release(input logic [2:0] btns, input int bounce,
                                   input int hold, input int rest);
    for (int i = 0; i < bounce; i++) send_tick(btns & 3'($urandom), pick_pot());
    for (int i = 0; i < hold; i++) send_tick(btns, pick_pot());
    for (int i = 0; i < bounce; i++) send_tick(btns & 3'($urandom), pick_pot());
    for (int i = 0; i < rest; i++) send_tick(3'b000, pick_pot());
  endtask

  // Mostly a single button, sometimes several at once to exercise priority.
  function automatic logic [2:0] pick_buttons();
    if ($urandom_range(0, 9) < 7) return 3'b001 << $urandom_range(0, 2);
    return 3'($urandom_range(1, 7));
  endfunction

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // With the reset settings, a forward press right after reset is still
  // inside the debounce and lockout windows, so the motor stays stopped.
  task automatic test_startup_lockout();
    send_tick(3'b010, '1);
    send_tick(3'b010, '0);
    for (int i = 0; i < 4; i++) send_tick(3'b010, pick_pot());
  endtask

  // Zero debounce accepts a level one tick after it changes and zero
  // cooldown lets every tick act. Also covers the stop-first, then forward,
  // then reverse priority and the duty at both ends of the sample range.
  task automatic test_zero_settings();
    set_timing(0, 0);
    send_tick(3'b010, POT_W'(1023));
    send_tick(3'b010, POT_W'(1022));
    send_tick(3'b111, POT_W'(1));
    send_tick(3'b111, POT_W'(0));
    send_tick(3'b000, POT_W'(512));
    send_tick(3'b000, POT_W'(511));
    send_tick(3'b110, POT_W'(1023));
    send_tick(3'b110, POT_W'(700));
    send_tick(3'b000, POT_W'(4));
    send_tick(3'b000, POT_W'(5));
    send_tick(3'b100, POT_W'(1023));
    send_tick(3'b100, POT_W'(1022));
    send_tick(3'b100, POT_W'(0));
  endtask

  // A new debounce setting is compared with the counts already running: a
  // forward hold too short for the largest setting is taken on the very next
  // tick once the setting drops below the count it has built up.
  task automatic test_register_change();
    set_timing(1023, 0);
    send_tick(3'b000, pick_pot());
    for (int i = 0; i < 6; i++) send_tick(3'b010, pick_pot());
    set_timing(2, 0);
    send_tick(3'b010, POT_W'(300));
    send_tick(3'b010, POT_W'(1023));
    send_tick(3'b000, pick_pot());
  endtask

  // Large settings and a long hold at full rate: the reverse press is taken
  // only once its stable count has run past two hundred ticks, and the
  // lockout count by then lies past its own setting as well.
  task automatic test_long_idle();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    set_timing(200, 300);
    for (int i = 0; i < 120; i++) send_tick(3'b000, pick_pot());
    for (int i = 0; i < 230; i++) send_tick(3'b100, pick_pot());
    for (int i = 0; i < 10; i++) send_tick(3'b000, pick_pot());
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // The receiver holds off for a long stretch while requests keep coming at
  // full rate, so the block fills up and must stall its input.
  task automatic test_backpressure();
    set_timing(1, 2);
    tx_gaps_on = 1'b0;
    hold_requests++;
    for (int i = 0; i < 6; i++)
      press_and_release(pick_buttons(), $urandom_range(0, 2), $urandom_range(1, 4),
                        $urandom_range(1, 5));
    tx_gaps_on = 1'b1;
  endtask

  // Random phases, each under its own timing setting. Most traffic is button
  // actions with bounce whose hold and rest lengths straddle the debounce and
  // lockout thresholds; the rest is random noise on all three buttons.
  task automatic test_random_presses();
    int goal;
    int phase_end;
    int phase;
    int deb;
    int cool;
    goal  = ticks_sent + RANDOM_TICKS;
    phase = 0;
    while (ticks_sent < goal) begin
      case (phase % 6)
        0: begin deb = 0; cool = 0; end
        1: begin deb = 1; cool = 3; end
        2: begin deb = 2; cool = 0; end
        3: begin deb = 0; cool = 12; end
        4: begin deb = $urandom_range(0, 4); cool = $urandom_range(0, 20); end
        default: begin deb = 3; cool = 30; end
      endcase
      set_timing(deb, cool);
      tx_gaps_on   = (phase % 3 != 2);
      rx_stalls_on = (phase % 4 != 3);
      phase_end = ticks_sent + PHASE_TICKS;
      while (ticks_sent < phase_end && ticks_sent < goal) begin
        if ($urandom_range(0, 3) != 0) begin
          press_and_release(pick_buttons(), $urandom_range(0, 3),
                            deb + $urandom_range(0, 4),
                            $urandom_range(deb, deb + cool + 4));
        end else begin
          repeat ($urandom_range(1, 8)) send_tick(3'($urandom), pick_pot());
        end
      end
      phase++;
    end
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------

  initial begin : run_tests
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_DEBOUNCE;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_stop_raw    = 1'b0;
    in_forward_raw = 1'b0;
    in_reverse_raw = 1'b0;
    in_pot_sample  = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    test_startup_lockout();
    test_zero_settings();
    test_register_change();
    test_long_idle();
    test_backpressure();
    test_random_presses();

    settle_block();
    if (pending_drives.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_drives.size()));
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
